// ----- rtl/sba_pkg.sv -----
// Shared types, field widths and codes for the sector bitmap allocator.
// No dependencies; every other file of the block but sba_ram imports this package.
package sba_pkg;

   // Map geometry
   localparam int NUM_SECTORS_DEF = 4096;
   localparam int SECTOR_BYTES    = 512;
   localparam int SECTOR_SHIFT    = $clog2(SECTOR_BYTES);
   localparam int WORD_BITS       = 32;
   localparam int WORD_SHIFT      = $clog2(WORD_BITS);

   // Field widths
   localparam int OP_W     = 2;
   localparam int BYTES_W  = 22;
   localparam int START_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int RSV_W    = 13;
   localparam int STATUS_W = 2;

   localparam logic [RSV_W-1:0] RESERVED_RESET = RSV_W'(152);

   typedef enum logic [OP_W-1:0] {
      OP_FORMAT = 2'd0,
      OP_FIND   = 2'd1,
      OP_ALLOC  = 2'd2,
      OP_FREE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_CLIPPED   = 2'd2
   } status_type;

   typedef struct packed {
      op_type               operation;
      logic [BYTES_W-1:0]   byte_size;
      logic [START_W-1:0]   start_sector;
      logic [COUNT_W-1:0]   sector_count;
   } req_type;

   typedef struct packed {
      logic [START_W-1:0]   run_start;
      status_type           status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic fill;
      logic mark;
      logic find;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;
   } sts_type;

endpackage

// ----- rtl/sector_bitmap_allocator_core.sv -----
// Top level of the sector bitmap allocator: controller, datapath and map RAM.
// Depends on sba_pkg, sba_ctrl, sba_datapath and sba_ram.
//
// One bit per sector is kept in a RAM of 32-bit words with one read port and
// one write port, each moving one word per cycle. A request beat is taken
// when start is high and busy is low; busy stays high until its result has
// been shown. Find reads the map from word 0 and stops at the first fit.
// Allocate and free touch only the words the run spans. Format rewrites every
// word. After reset a clearing pass over every word runs with busy high;
// configuration writes are taken at any time. Each result is on rsp_data for
// exactly one cycle with rsp_valid high and cannot be held off.
module sector_bitmap_allocator_core #(
   parameter int NUM_SECTORS = sba_pkg::NUM_SECTORS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  sba_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output sba_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [sba_pkg::RSV_W-1:0] csr_wr_data
);
   import sba_pkg::*;

   localparam int DEPTH  = (NUM_SECTORS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type               cmd;
   sts_type               sts;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [WORD_BITS-1:0]  ram_wdata;
   logic                  ram_re;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [WORD_BITS-1:0]  ram_rdata;

   sba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_data.operation),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   sba_datapath #(
      .NUM_SECTORS (NUM_SECTORS),
      .DEPTH       (DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .rsp_data    (rsp_data)
   );

   sba_ram #(
      .WIDTH  (WORD_BITS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// ----- rtl/sba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sba_ctrl.sv -----
// Controller state machine of the sector bitmap allocator.
// Depends on sba_pkg for the command, status and operation types.
module sba_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  sba_pkg::op_type req_op,
   input  sba_pkg::sts_type sts,
   output sba_pkg::cmd_type cmd,
   output logic            busy,
   output logic            rsp_valid
);
   import sba_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CLEAR = 6'b000010,
      S_FILL  = 6'b000100,
      S_MARK  = 6'b001000,
      S_FIND  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Pick the next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_op) inside
                  OP_FORMAT:         state_in = S_FILL;
                  OP_FIND:           state_in = S_FIND;
                  OP_ALLOC, OP_FREE: state_in = S_MARK;
                  default:           state_in = S_MARK;
               endcase
            end
         end
         S_CLEAR: begin
            if (sts.done) state_in = S_IDLE;
         end
         S_FILL, S_MARK, S_FIND: begin
            if (sts.done) state_in = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Clear the map after reset before the first request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Drive commands and handshake
   always_comb begin
      cmd.load  = (state_ff == S_IDLE) && start;
      cmd.fill  = (state_ff == S_CLEAR) || (state_ff == S_FILL);
      cmd.mark  = (state_ff == S_MARK);
      cmd.find  = (state_ff == S_FIND);
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// ----- rtl/sba_datapath.sv -----
// Datapath of the sector bitmap allocator: request decode, word sweeps over
// the map RAM, run search and the result register. Depends on sba_pkg.
module sba_datapath #(
   parameter int NUM_SECTORS = sba_pkg::NUM_SECTORS_DEF,
   parameter int DEPTH  = (NUM_SECTORS + sba_pkg::WORD_BITS - 1) / sba_pkg::WORD_BITS,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sba_pkg::cmd_type              cmd,
   output sba_pkg::sts_type              sts,
   input  sba_pkg::req_type              req_data,
   input  logic                          csr_wr_en,
   input  logic [sba_pkg::RSV_W-1:0]     csr_wr_data,
   output logic                          ram_we,
   output logic [ADDR_W-1:0]             ram_waddr,
   output logic [sba_pkg::WORD_BITS-1:0] ram_wdata,
   output logic                          ram_re,
   output logic [ADDR_W-1:0]             ram_raddr,
   input  logic [sba_pkg::WORD_BITS-1:0] ram_rdata,
   output sba_pkg::rsp_type              rsp_data
);
   import sba_pkg::*;

   localparam int WB        = WORD_BITS;
   localparam int WS        = WORD_SHIFT;
   localparam int AW1       = ADDR_W + 1;
   localparam int POS_W     = $clog2(NUM_SECTORS + 1);
   localparam int WIDE_W    = (POS_W >= 16) ? POS_W + 2 : 18;
   localparam int NEED_W    = BYTES_W - SECTOR_SHIFT + 1;
   localparam int LAST_BITS = NUM_SECTORS - (DEPTH - 1) * WB;
   localparam logic [WB-1:0] LAST_MASK = {WB{1'b1}} >> (WB - LAST_BITS);
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(DEPTH - 1);
   localparam logic [WIDE_W-1:0] MAP_END   = WIDE_W'(NUM_SECTORS);

   // Bits of word w that lie below sector position lim
   function automatic logic [WB-1:0] below_mask(input logic [ADDR_W-1:0] w,
                                                input logic [POS_W-1:0] lim);
      logic [AW1-1:0] lim_word;
      logic [WS-1:0]  lim_bit;
      logic [WB-1:0]  m;
      lim_word = AW1'(lim >> WS);
      lim_bit  = WS'(lim);
      if (AW1'(w) < lim_word) m = {WB{1'b1}};
      else if (AW1'(w) == lim_word) m = ~({WB{1'b1}} << lim_bit);
      else m = '0;
      return m;
   endfunction

   // Bits of word w that lie at or above sector position lim
   function automatic logic [WB-1:0] above_mask(input logic [ADDR_W-1:0] w,
                                                input logic [POS_W-1:0] lim);
      logic [AW1-1:0] lim_word;
      logic [WS-1:0]  lim_bit;
      logic [WB-1:0]  m;
      lim_word = AW1'(lim >> WS);
      lim_bit  = WS'(lim);
      if (AW1'(w) > lim_word) m = {WB{1'b1}};
      else if (AW1'(w) == lim_word) m = {WB{1'b1}} << lim_bit;
      else m = '0;
      return m;
   endfunction

   // Registers
   logic [RSV_W-1:0]  reserved_ff, reserved_in;
   logic              used_ff, used_in;
   logic [POS_W-1:0]  lo_ff, lo_in;
   logic [POS_W-1:0]  hi_ff, hi_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0] last_ff, last_in;
   logic              issue_ff, issue_in;
   logic              dval_ff, dval_in;
   logic [ADDR_W-1:0] dat_addr_ff, dat_addr_in;
   logic [POS_W-1:0]  run_ff, run_in;
   rsp_type           res_ff, res_in;

   // Request decode
   logic [NEED_W-1:0] need_raw;
   logic [NEED_W-1:0] need_ld;
   logic [WIDE_W-1:0] end_wide;
   logic              start_out;
   logic              mark_empty;
   logic              mark_clip;
   logic [POS_W-1:0]  mark_hi;
   logic              fmt_clip;
   logic [POS_W-1:0]  fmt_hi;

   // Search terms
   logic [WB-1:0]     free_bits;
   logic [WB-1:0]     dbl [WS+1];
   logic [WB-1:0]     window;
   logic [WS:0]       low_free;
   logic [WS:0]       top_free;
   logic [WS-1:0]     win_pos;
   logic [WIDE_W-1:0] base;
   logic              need_big;
   logic              carry_ok;
   logic              inword_ok;
   logic [WIDE_W-1:0] found_pos;
   logic [WB-1:0]     run_mask;

   // Decode one request beat
   always_comb begin
      need_raw   = NEED_W'(req_data.byte_size >> SECTOR_SHIFT)
                 + NEED_W'(|req_data.byte_size[SECTOR_SHIFT-1:0]);
      need_ld    = (need_raw == '0) ? NEED_W'(1) : need_raw;
      end_wide   = WIDE_W'(req_data.start_sector) + WIDE_W'(req_data.sector_count);
      start_out  = WIDE_W'(req_data.start_sector) >= MAP_END;
      mark_empty = start_out || (req_data.sector_count == '0);
      mark_clip  = start_out || (end_wide > MAP_END);
      mark_hi    = (end_wide > MAP_END) ? POS_W'(NUM_SECTORS) : POS_W'(end_wide);
      fmt_clip   = WIDE_W'(reserved_ff) > MAP_END;
      fmt_hi     = fmt_clip ? POS_W'(NUM_SECTORS) : POS_W'(reserved_ff);
   end

   // Scan one map word for a free run
   always_comb begin
      base      = WIDE_W'(dat_addr_ff) << WS;
      free_bits = ~ram_rdata & ((dat_addr_ff == LAST_WORD) ? LAST_MASK : {WB{1'b1}});
      need_big  = WIDE_W'(need_ff) > MAP_END;

      // free runs of length 2**k starting at each bit
      dbl[0] = free_bits;
      for (int k = 1; k <= WS; k++) begin
         dbl[k] = dbl[k-1] & (dbl[k-1] >> (1 << (k - 1)));
      end

      // compose a window of exactly need_ff bits from the binary digits
      window = {WB{1'b1}};
      for (int k = 0; k <= WS; k++) begin
         if (need_ff[k]) begin
            window = window & (dbl[k] >> (need_ff & NEED_W'((1 << k) - 1)));
         end
      end

      low_free = (WS+1)'(WB);
      win_pos  = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (!free_bits[i]) low_free = (WS+1)'(i);
         if (window[i]) win_pos = WS'(i);
      end

      top_free = (WS+1)'(WB);
      for (int i = 0; i < WB; i++) begin
         if (!free_bits[i]) top_free = (WS+1)'(WB - 1 - i);
      end

      carry_ok  = (WIDE_W'(run_ff) + WIDE_W'(low_free)) >= WIDE_W'(need_ff);
      inword_ok = (WIDE_W'(need_ff) <= WIDE_W'(WB)) && (window != '0);
      found_pos = carry_ok ? base - WIDE_W'(run_ff) : base + WIDE_W'(win_pos);
   end

   // Sequence sweeps, build write data and status
   always_comb begin
      reserved_in = reserved_ff;
      used_in     = used_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      need_in     = need_ff;
      rd_addr_in  = rd_addr_ff;
      last_in     = last_ff;
      issue_in    = issue_ff;
      dval_in     = 1'b0;
      dat_addr_in = rd_addr_ff;
      run_in      = run_ff;
      res_in      = res_ff;
      ram_we      = 1'b0;
      ram_waddr   = rd_addr_ff;
      ram_wdata   = below_mask(rd_addr_ff, hi_ff);
      ram_re      = 1'b0;
      ram_raddr   = rd_addr_ff;
      sts.done    = 1'b0;
      run_mask    = above_mask(dat_addr_ff, lo_ff) & below_mask(dat_addr_ff, hi_ff);

      if (csr_wr_en) begin
         reserved_in = csr_wr_data;
      end

      // set up the sweep for a new request
      if (cmd.load) begin
         rd_addr_in       = '0;
         last_in          = LAST_WORD;
         issue_in         = 1'b1;
         run_in           = '0;
         res_in.run_start = '0;
         unique case (req_data.operation)
            OP_FORMAT: begin
               hi_in         = fmt_hi;
               res_in.status = fmt_clip ? ST_CLIPPED : ST_DONE;
            end
            OP_FIND: begin
               need_in       = need_ld;
               res_in.status = ST_NOT_FOUND;
            end
            default: begin
               used_in       = (req_data.operation == OP_ALLOC);
               res_in.status = mark_clip ? ST_CLIPPED : ST_DONE;
               if (mark_empty) begin
                  lo_in   = '0;
                  hi_in   = '0;
                  last_in = '0;
               end else begin
                  lo_in      = POS_W'(req_data.start_sector);
                  hi_in      = mark_hi;
                  rd_addr_in = ADDR_W'(req_data.start_sector >> WS);
                  last_in    = ADDR_W'((mark_hi - POS_W'(1)) >> WS);
               end
            end
         endcase
      end

      // write fill words straight through the map
      if (cmd.fill) begin
         ram_we = 1'b1;
         if (rd_addr_ff == LAST_WORD) begin
            sts.done = 1'b1;
         end else begin
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
         end
      end

      // issue reads for read-modify-write and search
      if ((cmd.mark || cmd.find) && issue_ff) begin
         ram_re  = 1'b1;
         dval_in = 1'b1;
         if (rd_addr_ff == last_ff) begin
            issue_in = 1'b0;
         end else begin
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
         end
      end

      // write back the marked or cleared word
      if (cmd.mark && dval_ff) begin
         ram_we    = 1'b1;
         ram_waddr = dat_addr_ff;
         ram_wdata = used_ff ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
         sts.done  = (dat_addr_ff == last_ff);
      end

      // advance the run search
      if (cmd.find) begin
         if (need_big) begin
            sts.done = 1'b1;
         end else if (dval_ff) begin
            run_in = (free_bits == {WB{1'b1}}) ? run_ff + POS_W'(WB) : POS_W'(top_free);
            if (carry_ok || inword_ok) begin
               res_in.run_start = START_W'(found_pos);
               res_in.status    = ST_DONE;
               sts.done         = 1'b1;
            end else if (dat_addr_ff == LAST_WORD) begin
               sts.done = 1'b1;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= RESERVED_RESET;
         hi_ff       <= '0;
         rd_addr_ff  <= '0;
         issue_ff    <= 1'b0;
         dval_ff     <= 1'b0;
      end else begin
         reserved_ff <= reserved_in;
         hi_ff       <= hi_in;
         rd_addr_ff  <= rd_addr_in;
         issue_ff    <= issue_in;
         dval_ff     <= dval_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      used_ff     <= used_in;
      lo_ff       <= lo_in;
      need_ff     <= need_in;
      last_ff     <= last_in;
      dat_addr_ff <= dat_addr_in;
      run_ff      <= run_in;
      res_ff      <= res_in;
   end

   assign rsp_data = res_ff;

endmodule

// ----- rtl/sba_checker.sv -----
// Port-level checks of the sector bitmap allocator, bound to the top level.
// Depends on sba_pkg and sector_bitmap_allocator_core.
module sba_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input sba_pkg::rsp_type rsp_data
);
   import sba_pkg::*;

   // An accepted beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   // A result is shown only while busy and frees the block right after
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block still busy after result strobe");

   // A failed search reports sector zero
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_NOT_FOUND)) |-> (rsp_data.run_start == '0))
      else $error("not-found result with nonzero run start");

endmodule

bind sector_bitmap_allocator_core sba_checker u_sba_checker (.*);

// ----- tb/sv/sba_result_checker.sv -----
// Result checker for the sector bitmap allocator: keeps its own usage map,
// predicts the response to every request beat and compares it field by field.
// Depends on sba_pkg only; sees the block through its ports.
module sba_result_checker #(
   parameter int NUM_SECTORS = sba_pkg::NUM_SECTORS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  sba_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  sba_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [sba_pkg::RSV_W-1:0] csr_wr_data,
   output int                        fail_count,
   output int                        rsp_owed
);
   import sba_pkg::*;

   // Mirror of the block state: 1 marks a used sector
   bit [NUM_SECTORS-1:0] usage_bits;
   logic [RSV_W-1:0]     reserved_q;
   rsp_type              owed_rsp[$];
   rsp_type              oldest_rsp;
   int                   mismatch_count;
   int                   rsp_index;

   task automatic report_mismatch(input string what);
      $display("sba_result_checker: response %0d: %s", rsp_index, what);
      mismatch_count++;
   endtask

   // Set or clear a run, clipped at the map end
   function automatic status_type mark_span(input int unsigned first,
                                            input int unsigned len, input bit value);
      int unsigned stop;
      int unsigned s;
      status_type  st;
      st = ST_DONE;
      if (first >= NUM_SECTORS)
         return ST_CLIPPED;
      stop = first + len;
      if (stop > NUM_SECTORS) begin
         stop = NUM_SECTORS;
         st   = ST_CLIPPED;
      end
      for (s = first; s < stop; s++)
         usage_bits[s] = value;
      return st;
   endfunction

   // Apply one request to the mirrored map and return its response
   function automatic rsp_type predict_rsp(input req_type r);
      rsp_type     p;
      int unsigned need;
      int unsigned run_len;
      int unsigned s;
      p.run_start = '0;
      p.status    = ST_DONE;
      case (r.operation)
         OP_FORMAT: begin
            usage_bits = '0;
            p.status   = mark_span(0, reserved_q, 1'b1);
         end
         OP_FIND: begin
            // Round the byte size up to whole sectors, never below one
            need = r.byte_size >> SECTOR_SHIFT;
            if (r.byte_size[SECTOR_SHIFT-1:0] != '0)
               need++;
            if (need == 0)
               need = 1;
            p.status = ST_NOT_FOUND;
            run_len  = 0;
            if (need <= NUM_SECTORS) begin
               for (s = 0; s < NUM_SECTORS && p.status == ST_NOT_FOUND; s++) begin
                  run_len = usage_bits[s] ? 0 : run_len + 1;
                  if (run_len == need) begin
                     p.run_start = START_W'(s + 1 - need);
                     p.status    = ST_DONE;
                  end
               end
            end
         end
         OP_ALLOC: p.status = mark_span(r.start_sector, r.sector_count, 1'b1);
         default:  p.status = mark_span(r.start_sector, r.sector_count, 1'b0);
      endcase
      return p;
   endfunction

   // Retire the response of this edge first, then take the new request beat
   always @(posedge clock) begin
      if (reset) begin
         usage_bits = '0;
         reserved_q = RESERVED_RESET;
         owed_rsp.delete();
      end else begin
         if (csr_wr_en)
            reserved_q = csr_wr_data;
         if (rsp_valid) begin
            if (owed_rsp.size() == 0) begin
               report_mismatch($sformatf("no request pending, got run_start %0d status %0d",
                                         rsp_data.run_start, rsp_data.status));
            end else begin
               oldest_rsp = owed_rsp.pop_front();
               if (rsp_data.run_start !== oldest_rsp.run_start)
                  report_mismatch($sformatf("run_start %0d, want %0d",
                                            rsp_data.run_start, oldest_rsp.run_start));
               if (rsp_data.status !== oldest_rsp.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, oldest_rsp.status));
            end
            rsp_index++;
         end
         if (start && !busy)
            owed_rsp.push_back(predict_rsp(req_data));
      end
      rsp_owed   <= owed_rsp.size();
      fail_count <= mismatch_count;
   end

   initial begin
      mismatch_count = 0;
      rsp_index      = 0;
      rsp_owed       = 0;
      fail_count     = 0;
   end

endmodule

// ----- tb/sv/sector_bitmap_allocator_core_tb.sv -----
// Testbench top for the sector bitmap allocator core: clock, reset, request
// and register stimulus, watchdog and verdict. Depends on sba_pkg, the core
// and sba_result_checker, which does all prediction and comparison.
module sector_bitmap_allocator_core_tb;
   import sba_pkg::*;

   localparam int SECTORS        = NUM_SECTORS_DEF;
   localparam int PHASE_BEATS    = 255;
   localparam int MAX_GAP        = 140;
   localparam int SETTLE_CYCLES  = 160;
   localparam int QUIET_LIMIT    = 2000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [RSV_W-1:0] csr_wr_data;
   int               chk_fail_count;
   int               chk_owed;
   int               quiet_cycles;

   sector_bitmap_allocator_core #(
      .NUM_SECTORS (SECTORS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sba_result_checker #(
      .NUM_SECTORS (SECTORS)
   ) chk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (chk_fail_count),
      .rsp_owed    (chk_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: end the run after too long without any beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("sector_bitmap_allocator_core_tb: done, errors");
         $finish;
      end
   end

   function automatic req_type make_req(input op_type op, input int unsigned bytes,
                                        input int unsigned first, input int unsigned count);
      req_type r;
      r.operation    = op;
      r.byte_size    = BYTES_W'(bytes);
      r.start_sector = START_W'(first);
      r.sector_count = COUNT_W'(count);
      return r;
   endfunction

   // Mostly small runs and sizes so the map fragments; now and then full-width values
   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      r.byte_size    = BYTES_W'($urandom());
      r.start_sector = START_W'($urandom());
      r.sector_count = COUNT_W'($urandom());
      pick = $urandom_range(99);
      if (pick < 6)
         r.operation = OP_FORMAT;
      else if (pick < 46)
         r.operation = OP_FIND;
      else if (pick < 74)
         r.operation = OP_ALLOC;
      else
         r.operation = OP_FREE;
      pick = $urandom_range(99);
      if (pick < 60)
         r.byte_size = BYTES_W'($urandom_range(0, 32 * SECTOR_BYTES));
      else if (pick < 88)
         r.byte_size = BYTES_W'($urandom_range(0, 700 * SECTOR_BYTES));
      pick = $urandom_range(99);
      if (pick < 65)
         r.sector_count = COUNT_W'($urandom_range(0, 40));
      else if (pick < 90)
         r.sector_count = COUNT_W'($urandom_range(0, 700));
      if ($urandom_range(9) == 0)
         r.start_sector = START_W'($urandom_range(SECTORS - 64, SECTORS - 1));
      return r;
   endfunction

   // Present one beat and hold it until the core takes it
   task automatic drive_beat(input req_type r);
      req_data <= r;
      start    <= 1'b1;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending until every pending response has come back
   task automatic drain();
      start <= 1'b0;
      do
         @(posedge clock);
      while (chk_owed != 0);
   endtask

   task automatic write_reserved(input int unsigned value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= RSV_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int          reserved_plan [6];
      int          phase;
      int          idle_pct;
      int unsigned gap;
      reserved_plan = '{0, 4096, 8191, 4097, 0, 360};
      reserved_plan[4] = $urandom_range(1, SECTORS - 1);
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation, clipping and no-fit cases
      write_reserved(152);
      drive_beat(make_req(OP_FORMAT, 0, 0, 0));
      drive_beat(make_req(OP_FIND, 0, 0, 0));
      drive_beat(make_req(OP_FIND, 1, 0, 0));
      drive_beat(make_req(OP_FIND, 513, 0, 0));
      drive_beat(make_req(OP_FIND, 22'h3FFFFF, 0, 0));
      drive_beat(make_req(OP_FIND, 2097152, 0, 0));
      drive_beat(make_req(OP_ALLOC, 0, 152, 0));
      drive_beat(make_req(OP_ALLOC, 0, 4095, 8191));
      drive_beat(make_req(OP_ALLOC, 0, 4000, 96));
      drive_beat(make_req(OP_FREE, 0, 0, 4096));
      drive_beat(make_req(OP_FIND, 2097152, 0, 0));
      drive_beat(make_req(OP_ALLOC, 0, 0, 1));
      drive_beat(make_req(OP_FIND, 0, 0, 0));
      drive_beat(make_req(OP_FREE, 0, 100, 10));
      drive_beat(make_req(OP_ALLOC, 0, 0, 5));
      drive_beat(make_req(OP_ALLOC, 0, 2, 5));
      drive_beat(make_req(OP_FIND, 22'h2AAAAA, 0, 0));
      drive_beat(make_req(OP_FIND, 22'h155555, 0, 0));
      drive_beat(make_req(OP_FREE, 0, 4095, 4096));
      drive_beat(make_req(OP_ALLOC, 0, 12'hAAA, 13'h1555));
      drive_beat(make_req(OP_FREE, 0, 12'h555, 13'h0AAA));
      drive_beat(make_req(OP_FIND, 2097151, 0, 0));
      drive_beat(make_req(OP_FORMAT, 0, 0, 0));

      // Random phases, each under its own reserved count, with one idle rate shared by each pair of phases
      for (phase = 0; phase < 6; phase++) begin
         drain();
         write_reserved(reserved_plan[phase]);
         idle_pct = (phase < 2) ? 27 : (phase < 4) ? 70 : 0;
         repeat (PHASE_BEATS) begin
            if ($urandom_range(99) < idle_pct) begin
               gap = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_GAP)
                                              : $urandom_range(1, 4);
               hold_off(gap);
            end
            drive_beat(random_req());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (chk_fail_count == 0 && chk_owed == 0)
         $display("sector_bitmap_allocator_core_tb: done, clean");
      else
         $display("sector_bitmap_allocator_core_tb: done, errors");
      $finish;
   end

endmodule
